// ===== rtl/core/acwa_pkg.sv =====
// Shared sizes and lane control type for the capture window averager.
`default_nettype none
package acwa_pkg;

    // Window geometry and sample width
    localparam int WINDOW_LEN  = 8;
    localparam int SAMPLE_BITS = 16;

    // Derived widths
    localparam int HEAD_BITS = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int CNT_BITS  = $clog2(WINDOW_LEN + 1);
    localparam int SUM_BITS  = SAMPLE_BITS + $clog2(WINDOW_LEN);
    localparam int STEP_BITS = $clog2(SUM_BITS + 1);

    // Request kinds carried on tuser
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_TICK   = 1'b1;

    // Control from the sequencer to every lane
    typedef struct packed {
        logic                 load;    // apply a beat to ring and sum
        logic                 sample;  // 1: store new value, 0: clear head slot
        logic [HEAD_BITS-1:0] head;    // slot addressed by this beat
        logic                 step;    // one restoring divide step
    } lane_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/core/acwa_lane.sv =====
// One channel lane: ring slots, running sum and bit-serial divider.
`default_nettype none
module acwa_lane (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire acwa_pkg::lane_ctrl_t         ctrl,
    input  wire logic [acwa_pkg::SAMPLE_BITS-1:0] sample_in,
    input  wire logic [acwa_pkg::CNT_BITS-1:0]    divisor,
    output logic      [acwa_pkg::SAMPLE_BITS-1:0] quotient
);

    logic [acwa_pkg::SAMPLE_BITS-1:0] slot_reg [acwa_pkg::WINDOW_LEN];
    logic [acwa_pkg::SUM_BITS-1:0]    sum_reg, sum_next;
    logic [acwa_pkg::SUM_BITS-1:0]    quo_reg, quo_next;
    logic [acwa_pkg::CNT_BITS-1:0]    rem_reg, rem_next;
    logic [acwa_pkg::SAMPLE_BITS-1:0] stored;
    logic [acwa_pkg::CNT_BITS:0]      trial;

    // New slot content and updated sum
    always_comb begin
        stored   = ctrl.sample ? sample_in : '0;
        sum_next = sum_reg - acwa_pkg::SUM_BITS'(slot_reg[ctrl.head])
                   + acwa_pkg::SUM_BITS'(stored);
    end

    // Restoring divide step: shift in top dividend bit, try subtract
    always_comb begin
        trial    = {rem_reg, quo_reg[acwa_pkg::SUM_BITS-1]};
        quo_next = {quo_reg[acwa_pkg::SUM_BITS-2:0], 1'b0};
        rem_next = trial[acwa_pkg::CNT_BITS-1:0];
        if (trial >= {1'b0, divisor}) begin
            quo_next[0] = 1'b1;
            rem_next    = acwa_pkg::CNT_BITS'(trial - {1'b0, divisor});
        end
    end

    // Ring and sum, cleared at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < acwa_pkg::WINDOW_LEN; i++) begin
                slot_reg[i] <= '0;
            end
            sum_reg <= '0;
        end else if (ctrl.load) begin
            slot_reg[ctrl.head] <= stored;
            sum_reg             <= sum_next;
        end
    end

    // Divider datapath
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            quo_reg <= sum_next;
            rem_reg <= '0;
        end else if (ctrl.step) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    // Average is the low SAMPLE_BITS bits of the quotient
    assign quotient = quo_reg[acwa_pkg::SAMPLE_BITS-1:0];

endmodule
`default_nettype wire

// ===== rtl/core/acwa_merge.sv =====
// Merging stage: joins both lane results into the output register.
`default_nettype none
module acwa_merge (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             capture,
    input  wire logic [acwa_pkg::SAMPLE_BITS-1:0] pulse_q,
    input  wire logic [acwa_pkg::SAMPLE_BITS-1:0] period_q,
    output logic                                  free,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [31:0]                      m_tdata
);

    logic        valid_reg;
    logic [31:0] data_reg;

    // Room for a new result when empty or being drained this cycle
    assign free = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (capture) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (capture) begin
            data_reg <= {period_q, pulse_q};
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule
`default_nettype wire

// ===== rtl/core/aging_capture_window_average.sv =====
// Top level: sequencer, two channel lanes and the merging stage.
//
// Moving average of pulse and period captures over an 8-slot ring with
// expiry. A sample beat (tuser = 0) replaces the head slot; a timeout beat
// (tuser = 1) clears it and drops the entry count, and is dropped without a
// result when at most one entry remains. Every other beat yields one result
// holding both averages, each sum divided by the entry count and rounded
// down. Once a beat is taken, both lanes run a restoring divide of 19
// steps in parallel, one quotient bit per cycle, then the result moves to
// the output register when the merging stage has room; no new beat is taken
// until then. An ignored timeout keeps the input ready. The ring is cleared by reset.
`default_nettype none
module aging_capture_window_average (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // pulse_count[15:0], period_count[31:16]
    input  wire logic        s_tuser,   // req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata    // avg_pulse[15:0], avg_period[31:16]
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]                       state_reg, state_next;
    logic [acwa_pkg::HEAD_BITS-1:0]   head_reg, head_next;
    logic [acwa_pkg::CNT_BITS-1:0]    count_reg, count_next;
    logic [acwa_pkg::STEP_BITS-1:0]   step_reg, step_next;
    logic                             accept, act, capture, free;
    acwa_pkg::lane_ctrl_t             ctrl;
    logic [acwa_pkg::SAMPLE_BITS-1:0] pulse_q, period_q;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    // Timeout with at most one entry is swallowed
    assign act      = accept && !(s_tuser == acwa_pkg::REQ_TICK
                                  && count_reg <= acwa_pkg::CNT_BITS'(1));
    assign capture  = (state_reg == ST_DONE) && free;

    // Lane control
    always_comb begin
        ctrl.load   = act;
        ctrl.sample = (s_tuser == acwa_pkg::REQ_SAMPLE);
        ctrl.head   = head_reg;
        ctrl.step   = (state_reg == ST_DIV);
    end

    // Head, count and sequencer
    always_comb begin
        head_next  = head_reg;
        count_next = count_reg;
        step_next  = step_reg;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (act) begin
                    head_next = (head_reg == acwa_pkg::HEAD_BITS'(acwa_pkg::WINDOW_LEN - 1))
                                ? '0 : head_reg + 1'b1;
                    if (s_tuser == acwa_pkg::REQ_SAMPLE) begin
                        if (count_reg < acwa_pkg::CNT_BITS'(acwa_pkg::WINDOW_LEN)) begin
                            count_next = count_reg + 1'b1;
                        end
                    end else begin
                        count_next = count_reg - 1'b1;
                    end
                    step_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                step_next = step_reg + 1'b1;
                if (step_reg == acwa_pkg::STEP_BITS'(acwa_pkg::SUM_BITS - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            step_reg  <= step_next;
        end
    end

    // Pulse channel
    acwa_lane u_lane_pulse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .sample_in (s_tdata[15:0]),
        .divisor   (count_reg),
        .quotient  (pulse_q)
    );

    // Period channel
    acwa_lane u_lane_period (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .sample_in (s_tdata[31:16]),
        .divisor   (count_reg),
        .quotient  (period_q)
    );

    acwa_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .capture  (capture),
        .pulse_q  (pulse_q),
        .period_q (period_q),
        .free     (free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
`default_nettype wire

// ===== tb/tb_aging_capture_window_average.sv =====
// Testbench for the capture window averager: directed and random beats against a scoreboard.
`timescale 1ns / 100ps

// Expected averages for one result beat
typedef struct packed {
    logic [15:0] avg_period;
    logic [15:0] avg_pulse;
} avg_pair_t;

// Tracks the ring, sums, head and count, and queues the expected averages
class window_scoreboard;
    logic [acwa_pkg::SAMPLE_BITS-1:0] ring_pulse [acwa_pkg::WINDOW_LEN];
    logic [acwa_pkg::SAMPLE_BITS-1:0] ring_period[acwa_pkg::WINDOW_LEN];
    logic [acwa_pkg::SUM_BITS-1:0]    pulse_total;
    logic [acwa_pkg::SUM_BITS-1:0]    period_total;
    logic [acwa_pkg::HEAD_BITS-1:0]   head;
    logic [acwa_pkg::CNT_BITS-1:0]    fill;
    avg_pair_t                        expected_avgs[$];
    int                               errors;

    function new();
        for (int i = 0; i < acwa_pkg::WINDOW_LEN; i++) begin
            ring_pulse[i]  = '0;
            ring_period[i] = '0;
        end
        pulse_total  = '0;
        period_total = '0;
        head         = '0;
        fill         = '0;
        errors       = 0;
    endfunction

    // Apply an accepted input beat; returns 1 when it yields a result
    function bit note_input(logic req, logic [15:0] pulse, logic [15:0] period);
        avg_pair_t avgs;
        // timeout with at most one entry left is dropped
        if (req == acwa_pkg::REQ_TICK && fill <= 1)
            return 1'b0;
        pulse_total  = pulse_total - ring_pulse[head];
        period_total = period_total - ring_period[head];
        if (req == acwa_pkg::REQ_SAMPLE) begin
            ring_pulse[head]  = pulse;
            ring_period[head] = period;
            pulse_total       = pulse_total + pulse;
            period_total      = period_total + period;
            if (fill < acwa_pkg::WINDOW_LEN)
                fill = fill + 1'b1;
        end else begin
            ring_pulse[head]  = '0;
            ring_period[head] = '0;
            fill              = fill - 1'b1;
        end
        head = (head == acwa_pkg::WINDOW_LEN - 1) ? '0 : head + 1'b1;
        avgs.avg_pulse  = 16'(pulse_total / fill);
        avgs.avg_period = 16'(period_total / fill);
        expected_avgs.push_back(avgs);
        return 1'b1;
    endfunction

    // Compare a result beat with the oldest expectation
    function void check_result(logic [31:0] data);
        avg_pair_t want;
        avg_pair_t got;
        got = data;
        if (expected_avgs.size() == 0) begin
            $display("%0t: unexpected result beat, expected none, got %h", $time, data);
            errors++;
            return;
        end
        want = expected_avgs.pop_front();
        if (got.avg_pulse !== want.avg_pulse) begin
            $display("%0t: avg_pulse mismatch, expected %0d, got %0d",
                     $time, want.avg_pulse, got.avg_pulse);
            errors++;
        end
        if (got.avg_period !== want.avg_period) begin
            $display("%0t: avg_period mismatch, expected %0d, got %0d",
                     $time, want.avg_period, got.avg_period);
            errors++;
        end
    endfunction

    function int pending();
        return expected_avgs.size();
    endfunction
endclass

module tb_aging_capture_window_average;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int RANDOM_ITEMS = 1050;
    localparam int IDLE_PCT     = 34;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    // set during the stretch with no idling on either side
    bit          quiet    = 1'b0;
    int          cycles   = 0;

    window_scoreboard sb = new();

    aging_capture_window_average i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Result side: random back-pressure, check each accepted beat
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
        m_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Drive one input beat with random idle cycles ahead of it; returns when accepted
    task automatic send_beat(input logic req, input logic [15:0] pulse,
                             input logic [15:0] period, output bit gives_result);
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            s_tuser  <= 1'($urandom_range(0, 1));
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {period, pulse};
        do
            @(posedge aclk);
        while (!(s_tvalid && s_tready));
        gives_result = sb.note_input(req, pulse, period);
    endtask

    // Capture value biased towards the extremes
    function automatic logic [15:0] pick_capture();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hffff;
            2:       return 16'($urandom_range(0, 15));
            3:       return 16'hfff0 | 16'($urandom_range(0, 15));
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        bit          res;
        int          counted;
        int          tick_pct;
        logic        req;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: ticks on an empty and a single-entry window are dropped
        send_beat(acwa_pkg::REQ_TICK, 16'hffff, 16'hffff, res);
        send_beat(acwa_pkg::REQ_SAMPLE, 16'hffff, 16'hffff, res);
        send_beat(acwa_pkg::REQ_TICK, 16'h1234, 16'habcd, res);
        send_beat(acwa_pkg::REQ_SAMPLE, 16'h0000, 16'h0000, res);
        // tick on a window that is not full clears an empty slot
        send_beat(acwa_pkg::REQ_TICK, 16'hffff, 16'h0000, res);
        // fill past the window length with the largest captures, wrapping the head
        repeat (9) send_beat(acwa_pkg::REQ_SAMPLE, 16'hffff, 16'hffff, res);
        send_beat(acwa_pkg::REQ_TICK, 16'h5555, 16'haaaa, res);
        send_beat(acwa_pkg::REQ_SAMPLE, 16'h0001, 16'h0001, res);
        // drain down to one entry, then one more tick is dropped
        repeat (8) send_beat(acwa_pkg::REQ_TICK, 16'($urandom), 16'($urandom), res);

        // Random: phases with differing tick rates, quiet stretch in the middle
        counted  = 0;
        tick_pct = 10;
        while (counted < RANDOM_ITEMS) begin
            if (counted % 64 == 0) begin
                case ($urandom_range(0, 3))
                    0:       tick_pct = 5;
                    1:       tick_pct = 25;
                    2:       tick_pct = 50;
                    default: tick_pct = 75;
                endcase
            end
            quiet = (counted >= 400 && counted < 550);
            req   = ($urandom_range(0, 99) < tick_pct) ? acwa_pkg::REQ_TICK
                                                       : acwa_pkg::REQ_SAMPLE;
            send_beat(req, pick_capture(), pick_capture(), res);
            counted++;
        end

        // Drain
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (60) @(posedge aclk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/acwa_pkg.sv
rtl/core/acwa_lane.sv
rtl/core/acwa_merge.sv
rtl/core/aging_capture_window_average.sv
tb/tb_aging_capture_window_average.sv
